@@ rtl/atrp_pkg.sv @@
// ----------------------------------------------------------------------------
// atrp_pkg: shared types and constants of the AT response parser
// Parser state codes, status codes, mode codes, character constants and the
// result record carried from the step logic to the output register.
// ----------------------------------------------------------------------------
package atrp_pkg;

  // parser states; codes 6 and 23..31 are never entered
  typedef enum logic [4:0] {
    PS_IDLE       = 5'd0,   // waiting for the leading CR
    PS_LEAD_LF    = 5'd1,   // leading LF
    PS_BODY       = 5'd2,   // first character after CR LF
    PS_OK_K       = 5'd3,   // got 'O', expecting 'K'
    PS_END_CR     = 5'd4,   // CR after OK or ERROR
    PS_END_LF     = 5'd5,   // final LF
    PS_ERR_R1     = 5'd7,
    PS_ERR_R2     = 5'd8,
    PS_ERR_O      = 5'd9,
    PS_ERR_R3     = 5'd10,
    PS_INFO       = 5'd11,  // information or raw line text
    PS_INFO_LF    = 5'd12,
    PS_INFO_NEXT  = 5'd13,  // next info line or blank line
    PS_TAIL_LF    = 5'd14,
    PS_TAIL       = 5'd15,  // OK or ERROR after info lines
    PS_SMS_HDR    = 5'd16,  // sms header text
    PS_SMS_HDR_LF = 5'd17,
    PS_SMS_BODY   = 5'd18,  // sms body text
    PS_SMS_LF     = 5'd19,
    PS_SMS_CR2    = 5'd20,
    PS_SMS_LF2    = 5'd21,
    PS_SMS_NEXT   = 5'd22   // next sms pair or final code
  } parse_state_t;

  // status codes per byte
  typedef enum logic [1:0] {
    STAT_NOT_READY = 2'd0,
    STAT_OK        = 2'd1,
    STAT_ERROR     = 2'd2
  } status_t;

  // line store action of one byte
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_PUT   = 2'd1,  // capture a character
    ACT_END   = 2'd2,  // terminate the line
    ACT_CLEAR = 2'd3   // new response, clear the line count
  } action_t;

  // command mode codes; code 3 matches none of them
  localparam logic [1:0] MODE_USUAL   = 2'd0;
  localparam logic [1:0] MODE_SMS     = 2'd1;
  localparam logic [1:0] MODE_SPECIAL = 2'd2;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_K     = 8'h4b;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  // one result transaction
  typedef struct packed {
    logic [3:0] lines_captured;
    logic [7:0] store_char;
    logic [5:0] store_col;
    logic [2:0] store_line;
    logic       store_valid;
    status_t    status;
  } result_t;

endpackage

@@ rtl/at_response_parser.sv @@
// ----------------------------------------------------------------------------
// at_response_parser: AT command response parser, top level
// Input byte register, parser state registers and output result register.
// ----------------------------------------------------------------------------
// Takes one received modem byte per transaction on the s_ side and returns
// one result transaction per byte on the m_ side: a status (not ready, ok,
// error), an optional capture into a line store of MAX_LINES lines by
// LINE_SIZE columns, and the number of lines captured so far. The block
// accepts one byte every clock cycle when the output side keeps up. A byte
// is held in the input register while the combinational state transition
// works on it, and its result is loaded into the result register once the
// output side can take it and is offered from there on the m_ side. The
// state transition of one byte feeds the next byte directly, which sets the
// one-byte-per-cycle rate. command_mode is written through cfg_we /
// cfg_wdata; the user must write it only while no transaction is in
// flight, and the block itself does not enforce this.
module at_response_parser #(
  parameter int MAX_LINES = 8,
  parameter int LINE_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,    // [1:0] command_mode
  // received bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] rx_byte
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [2] store_valid, [5:3] store_line, [11:6] store_col,
  // [19:12] store_char, [23:20] lines_captured
  output logic [23:0] m_tdata
);

  localparam int CW = $clog2(LINE_SIZE);
  localparam int LW = $clog2(MAX_LINES + 1);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   out_valid;
  atrp_pkg::result_t      out_res;
  logic [1:0]             command_mode;
  atrp_pkg::parse_state_t parse_state;
  atrp_pkg::parse_state_t parse_state_next;
  logic [CW-1:0]          column;
  logic [CW-1:0]          column_next;
  logic [LW-1:0]          line_num;
  logic [LW-1:0]          line_num_next;
  atrp_pkg::result_t      res;
  logic                   advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_res;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      command_mode <= atrp_pkg::MODE_USUAL;
    end else if (cfg_we) begin
      command_mode <= cfg_wdata;
    end
  end

  // input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // state transition for the registered byte
  atrp_step #(
    .MAX_LINES (MAX_LINES),
    .LINE_SIZE (LINE_SIZE)
  ) u_step (
    .rx_byte          (in_byte),
    .command_mode     (command_mode),
    .parse_state      (parse_state),
    .column           (column),
    .line_num         (line_num),
    .parse_state_next (parse_state_next),
    .column_next      (column_next),
    .line_num_next    (line_num_next),
    .res              (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= atrp_pkg::PS_IDLE;
      column      <= '0;
      line_num    <= '0;
    end else if (advance) begin
      parse_state <= parse_state_next;
      column      <= column_next;
      line_num    <= line_num_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  // line count stays within the store
  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    32'(line_num) <= 32'(MAX_LINES))
    else $error("line count beyond store");

  // column stays within a line
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    32'(column) < 32'(LINE_SIZE))
    else $error("column beyond line size");

  // an error byte never captures a character
  a_err_no_store: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status == atrp_pkg::STAT_ERROR) |-> !out_res.store_valid)
    else $error("capture on error byte");

  // a completed response returns the parser to idle
  a_ok_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && res.status == atrp_pkg::STAT_OK) |=> parse_state == atrp_pkg::PS_IDLE)
    else $error("parser not idle after ok");

endmodule

@@ rtl/atrp_step.sv @@
// ----------------------------------------------------------------------------
// atrp_step: next-state and capture logic for one received byte
// Decodes the byte against the parser state and command mode, and works out
// the next state, column, line count and the result transaction.
// ----------------------------------------------------------------------------
module atrp_step #(
  parameter int MAX_LINES = 8,
  parameter int LINE_SIZE = 64,
  localparam int CW = $clog2(LINE_SIZE),
  localparam int LW = $clog2(MAX_LINES + 1)
) (
  input  logic [7:0]             rx_byte,
  input  logic [1:0]             command_mode,
  input  atrp_pkg::parse_state_t parse_state,
  input  logic [CW-1:0]          column,
  input  logic [LW-1:0]          line_num,
  output atrp_pkg::parse_state_t parse_state_next,
  output logic [CW-1:0]          column_next,
  output logic [LW-1:0]          line_num_next,
  output atrp_pkg::result_t      res
);

  logic                printable;
  logic                line_room;
  logic                col_room;
  atrp_pkg::status_t   status;
  atrp_pkg::action_t   act;
  logic [7:0]          put_value;
  logic [31:0]         col_ext;
  logic [31:0]         line_ext;
  logic [31:0]         line_next_ext;

  assign printable = (rx_byte >= atrp_pkg::PRINT_LO) && (rx_byte <= atrp_pkg::PRINT_HI);
  assign line_room = 32'(line_num) < 32'(MAX_LINES);
  assign col_room  = 32'(column) < 32'(LINE_SIZE - 1);

  // next state
  always_comb begin
    parse_state_next = parse_state;
    unique case (parse_state)
      atrp_pkg::PS_IDLE: begin
        if (rx_byte == atrp_pkg::CH_CR) parse_state_next = atrp_pkg::PS_LEAD_LF;
      end
      atrp_pkg::PS_LEAD_LF: begin
        if (rx_byte == atrp_pkg::CH_LF) begin
          parse_state_next = (command_mode == atrp_pkg::MODE_SPECIAL) ?
                             atrp_pkg::PS_INFO : atrp_pkg::PS_BODY;
        end
      end
      atrp_pkg::PS_BODY, atrp_pkg::PS_TAIL, atrp_pkg::PS_SMS_NEXT: begin
        if (rx_byte == atrp_pkg::CH_O) begin
          parse_state_next = atrp_pkg::PS_OK_K;
        end else if (rx_byte == atrp_pkg::CH_E) begin
          parse_state_next = atrp_pkg::PS_ERR_R1;
        end else if (rx_byte == atrp_pkg::CH_PLUS) begin
          if (parse_state == atrp_pkg::PS_SMS_NEXT) begin
            parse_state_next = atrp_pkg::PS_SMS_HDR;
          end else if (parse_state == atrp_pkg::PS_BODY) begin
            if (command_mode == atrp_pkg::MODE_USUAL) parse_state_next = atrp_pkg::PS_INFO;
            else if (command_mode == atrp_pkg::MODE_SMS) parse_state_next = atrp_pkg::PS_SMS_HDR;
          end
        end
      end
      atrp_pkg::PS_OK_K: begin
        if (rx_byte == atrp_pkg::CH_K) parse_state_next = atrp_pkg::PS_END_CR;
      end
      atrp_pkg::PS_END_CR: begin
        if (rx_byte == atrp_pkg::CH_CR) parse_state_next = atrp_pkg::PS_END_LF;
      end
      atrp_pkg::PS_END_LF: begin
        if (rx_byte == atrp_pkg::CH_LF) parse_state_next = atrp_pkg::PS_IDLE;
      end
      atrp_pkg::PS_ERR_R1: begin
        if (rx_byte == atrp_pkg::CH_R) parse_state_next = atrp_pkg::PS_ERR_R2;
      end
      atrp_pkg::PS_ERR_R2: begin
        if (rx_byte == atrp_pkg::CH_R) parse_state_next = atrp_pkg::PS_ERR_O;
      end
      atrp_pkg::PS_ERR_O: begin
        if (rx_byte == atrp_pkg::CH_O) parse_state_next = atrp_pkg::PS_ERR_R3;
      end
      atrp_pkg::PS_ERR_R3: begin
        if (rx_byte == atrp_pkg::CH_R) parse_state_next = atrp_pkg::PS_END_CR;
      end
      atrp_pkg::PS_INFO, atrp_pkg::PS_SMS_BODY: begin
        if (!printable && rx_byte == atrp_pkg::CH_CR) begin
          parse_state_next = (parse_state == atrp_pkg::PS_INFO) ?
                             atrp_pkg::PS_INFO_LF : atrp_pkg::PS_SMS_LF;
        end
      end
      atrp_pkg::PS_INFO_LF: begin
        if (rx_byte == atrp_pkg::CH_LF) parse_state_next = atrp_pkg::PS_INFO_NEXT;
      end
      atrp_pkg::PS_INFO_NEXT: begin
        if (rx_byte == atrp_pkg::CH_PLUS && command_mode == atrp_pkg::MODE_USUAL) begin
          parse_state_next = atrp_pkg::PS_INFO;
        end else if (rx_byte == atrp_pkg::CH_CR) begin
          parse_state_next = atrp_pkg::PS_TAIL_LF;
        end
      end
      atrp_pkg::PS_TAIL_LF: begin
        if (rx_byte == atrp_pkg::CH_LF) parse_state_next = atrp_pkg::PS_TAIL;
      end
      atrp_pkg::PS_SMS_HDR: begin
        if (!printable && rx_byte == atrp_pkg::CH_CR) parse_state_next = atrp_pkg::PS_SMS_HDR_LF;
      end
      atrp_pkg::PS_SMS_HDR_LF: begin
        if (rx_byte == atrp_pkg::CH_LF) parse_state_next = atrp_pkg::PS_SMS_BODY;
      end
      atrp_pkg::PS_SMS_LF: begin
        if (rx_byte == atrp_pkg::CH_LF) parse_state_next = atrp_pkg::PS_SMS_CR2;
      end
      atrp_pkg::PS_SMS_CR2: begin
        if (rx_byte == atrp_pkg::CH_CR) parse_state_next = atrp_pkg::PS_SMS_LF2;
      end
      atrp_pkg::PS_SMS_LF2: begin
        if (rx_byte == atrp_pkg::CH_LF) parse_state_next = atrp_pkg::PS_SMS_NEXT;
      end
      default: parse_state_next = atrp_pkg::PS_IDLE;
    endcase
  end

  // status and line store action
  always_comb begin
    status = atrp_pkg::STAT_NOT_READY;
    act    = atrp_pkg::ACT_NONE;
    unique case (parse_state)
      atrp_pkg::PS_IDLE: begin
        if (rx_byte == atrp_pkg::CH_CR) act = atrp_pkg::ACT_CLEAR;
      end
      atrp_pkg::PS_LEAD_LF, atrp_pkg::PS_INFO_LF, atrp_pkg::PS_TAIL_LF,
      atrp_pkg::PS_SMS_LF, atrp_pkg::PS_SMS_LF2: begin
        if (rx_byte != atrp_pkg::CH_LF) status = atrp_pkg::STAT_ERROR;
      end
      atrp_pkg::PS_BODY, atrp_pkg::PS_TAIL, atrp_pkg::PS_SMS_NEXT: begin
        if (rx_byte != atrp_pkg::CH_O && rx_byte != atrp_pkg::CH_E &&
            rx_byte != atrp_pkg::CH_PLUS) begin
          status = atrp_pkg::STAT_ERROR;
        end else if (rx_byte == atrp_pkg::CH_PLUS && parse_state == atrp_pkg::PS_TAIL) begin
          status = atrp_pkg::STAT_ERROR;
        end
      end
      atrp_pkg::PS_OK_K: begin
        if (rx_byte != atrp_pkg::CH_K) status = atrp_pkg::STAT_ERROR;
      end
      atrp_pkg::PS_END_CR, atrp_pkg::PS_SMS_CR2: begin
        if (rx_byte != atrp_pkg::CH_CR) status = atrp_pkg::STAT_ERROR;
      end
      atrp_pkg::PS_END_LF: begin
        status = (rx_byte == atrp_pkg::CH_LF) ? atrp_pkg::STAT_OK : atrp_pkg::STAT_ERROR;
      end
      atrp_pkg::PS_ERR_R1, atrp_pkg::PS_ERR_R2, atrp_pkg::PS_ERR_R3: begin
        if (rx_byte != atrp_pkg::CH_R) status = atrp_pkg::STAT_ERROR;
      end
      atrp_pkg::PS_ERR_O: begin
        if (rx_byte != atrp_pkg::CH_O) status = atrp_pkg::STAT_ERROR;
      end
      atrp_pkg::PS_INFO, atrp_pkg::PS_SMS_BODY: begin
        if (printable) act = atrp_pkg::ACT_PUT;
        else if (rx_byte == atrp_pkg::CH_CR) act = atrp_pkg::ACT_END;
        else status = atrp_pkg::STAT_ERROR;
      end
      atrp_pkg::PS_INFO_NEXT: begin
        if (!((rx_byte == atrp_pkg::CH_PLUS && command_mode == atrp_pkg::MODE_USUAL) ||
              rx_byte == atrp_pkg::CH_CR)) begin
          status = atrp_pkg::STAT_ERROR;
        end
      end
      atrp_pkg::PS_SMS_HDR: begin
        if (printable) act = atrp_pkg::ACT_PUT;
        else if (rx_byte != atrp_pkg::CH_CR) status = atrp_pkg::STAT_ERROR;
      end
      atrp_pkg::PS_SMS_HDR_LF: begin
        // the newline between header and body is captured too
        if (rx_byte == atrp_pkg::CH_LF) act = atrp_pkg::ACT_PUT;
        else status = atrp_pkg::STAT_ERROR;
      end
      default: begin
        status = atrp_pkg::STAT_NOT_READY;
      end
    endcase
  end

  // line store bookkeeping
  always_comb begin
    column_next     = column;
    line_num_next   = line_num;
    res             = '0;
    res.status      = status;
    put_value       = atrp_pkg::CH_NUL;
    col_ext         = 32'(column);
    line_ext        = 32'(line_num);
    case (act)
      atrp_pkg::ACT_PUT: begin
        if (line_room && col_room) begin
          res.store_valid = 1'b1;
          put_value       = rx_byte;
          column_next     = CW'(column + 1'b1);
        end
      end
      atrp_pkg::ACT_END: begin
        if (line_room) begin
          res.store_valid = 1'b1;
          column_next     = '0;
          line_num_next   = LW'(line_num + 1'b1);
        end
      end
      atrp_pkg::ACT_CLEAR: line_num_next = '0;
      default: line_num_next = line_num;
    endcase
    if (res.store_valid) begin
      res.store_line = line_ext[2:0];
      res.store_col  = col_ext[5:0];
      res.store_char = put_value;
    end
    line_next_ext      = 32'(line_num_next);
    res.lines_captured = line_next_ext[3:0];
  end

endmodule
